// File: src/lcdseq_pkg.sv
// Shared types, phase codes, command codes and byte constants for the
// character display sequencer. No dependencies; every other file imports it.
package lcdseq_pkg;

  // Line store geometry: two lines of sixteen stored characters.
  localparam int unsigned ROW_STRIDE   = 16;
  localparam int unsigned ROW_AW       = 4;
  localparam int unsigned STORE_DEPTH  = 32;
  localparam int unsigned STORE_AW     = 5;
  localparam int unsigned LINE_LEN_DEF = 16;

  // Item commands.
  localparam logic [2:0] CMD_POLL = 3'd0;
  localparam logic [2:0] CMD_LOAD = 3'd1;
  localparam logic [2:0] CMD_SEND = 3'd2;
  localparam logic [2:0] CMD_ON   = 3'd3;
  localparam logic [2:0] CMD_OFF  = 3'd4;

  // Sequencer phases.
  localparam int unsigned PH_W = 4;
  localparam logic [PH_W-1:0] PH_INIT_START = 4'd0;
  localparam logic [PH_W-1:0] PH_FS0        = 4'd1;
  localparam logic [PH_W-1:0] PH_FS1        = 4'd2;
  localparam logic [PH_W-1:0] PH_FS2        = 4'd3;
  localparam logic [PH_W-1:0] PH_FS3        = 4'd4;
  localparam logic [PH_W-1:0] PH_FUNC       = 4'd5;
  localparam logic [PH_W-1:0] PH_CTRL       = 4'd6;
  localparam logic [PH_W-1:0] PH_CLEAR      = 4'd7;
  localparam logic [PH_W-1:0] PH_SEND_START = 4'd8;
  localparam logic [PH_W-1:0] PH_CURSOR0    = 4'd9;
  localparam logic [PH_W-1:0] PH_TEXT0      = 4'd10;
  localparam logic [PH_W-1:0] PH_CURSOR1    = 4'd11;
  localparam logic [PH_W-1:0] PH_TEXT1      = 4'd12;
  localparam logic [PH_W-1:0] PH_TURN_OFF   = 4'd13;
  localparam logic [PH_W-1:0] PH_IDLE_OFF   = 4'd14;
  localparam logic [PH_W-1:0] PH_IDLE_ON    = 4'd15;

  // Display controller bytes and nibbles.
  localparam logic [3:0] NIB_FS8     = 4'h3;
  localparam logic [3:0] NIB_FS4     = 4'h2;
  localparam logic [7:0] BYTE_FUNC   = 8'h2C;  // function set, 2 lines, 5x10
  localparam logic [7:0] BYTE_CTRL   = 8'h0C;  // display on
  localparam logic [7:0] BYTE_CLEAR  = 8'h01;
  localparam logic [7:0] BYTE_LINE0  = 8'h80;
  localparam logic [7:0] BYTE_LINE1  = 8'hC0;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;

  // Millisecond waits.
  localparam logic [5:0] WAIT_SHORT = 6'd2;
  localparam logic [5:0] WAIT_STEP  = 6'd5;
  localparam logic [5:0] WAIT_LINE  = 6'd10;
  localparam logic [5:0] WAIT_CLEAR = 6'd15;
  localparam logic [5:0] WAIT_POWER = 6'd50;
  localparam logic [5:0] MS_MAX     = 6'd63;

  // Index of the last result of an item.
  localparam logic [1:0] LAST_NONE   = 2'd0;
  localparam logic [1:0] LAST_NIBBLE = 2'd1;
  localparam logic [1:0] LAST_BYTE   = 2'd3;

  // Scalar sequencer state, apart from the column counter.
  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic [5:0]      wait_ms;
    logic [5:0]      elapsed_ms;
    logic            line_ended;
  } ctl_t;

  // Everything needed to produce the results of one item.
  typedef struct packed {
    logic       byte_valid;
    logic [1:0] last_idx;
    logic [3:0] nib_hi;
    logic [3:0] nib_lo;
    logic       rs;
    logic       bl;
    logic       ready;
    logic       lit;
  } res_t;

  function automatic logic phase_lit(input logic [PH_W-1:0] ph);
    return (ph != PH_TURN_OFF) && (ph != PH_IDLE_OFF);
  endfunction

endpackage

// File: src/char_lcd_nibble_sequencer.sv
// Top level of the character display sequencer: input and work stages,
// sequencer state, line store, step logic and output stage. Uses lcdseq_pkg.
//
//   channel   direction  payload
//   in_*      input      tuser: cmd; tdata: ms_passed, char_index, char_code
//   out_*     output     tuser: byte_valid; tdata: bus_byte, ready_res, lit, address
//   cfg_*     input      device_address, written when cfg_wr_en is high
//
// One result leaves per cycle while out_tready is high; an item gives one, two or four results,
// and a character or command step gives four.
// An accepted item and its store read are registered in the work stage, then its step result in the output stage.
// An item is taken whenever the work stage is empty or hands over to the output stage.
// Reset clears state and store valid bits at once; items are taken right after reset.
module char_lcd_nibble_sequencer #(
  parameter int unsigned LINE_LENGTH = lcdseq_pkg::LINE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // ms_passed[0], char_index[5:1], char_code[13:6]
  input  logic [2:0]  in_tuser,    // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // bus_byte[7:0], ready_res[8], lit[9], target_address[16:10]
  output logic        out_tuser,   // byte_valid
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);
  import lcdseq_pkg::*;

  localparam int unsigned COL_W = $clog2(LINE_LENGTH + 1);

  logic                in_acc;
  logic                s1_valid_r;
  logic [2:0]          s1_cmd_r;
  logic                s1_ms_r;
  logic                s1_adv;
  logic                emit_free;
  ctl_t                ctl_r;
  ctl_t                ctl_nxt;
  ctl_t                step_ctl;
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    col_nxt;
  logic [COL_W-1:0]    step_col;
  res_t                step_res;
  logic [7:0]          store_data;
  logic [STORE_AW-1:0] rd_addr;
  logic [6:0]          dev_addr_r;

  assign s1_adv    = s1_valid_r && emit_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // State as it stands once the work stage commits.
  assign ctl_nxt = s1_adv ? step_ctl : ctl_r;
  assign col_nxt = s1_adv ? step_col : col_r;
  assign rd_addr = {(ctl_nxt.phase == PH_TEXT1), col_nxt[ROW_AW-1:0]};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd0;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  // Work stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Work stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_tuser;
      s1_ms_r  <= in_tdata[0];
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_INIT_START;
      ctl_r.wait_ms    <= '0;
      ctl_r.elapsed_ms <= '0;
      ctl_r.line_ended <= 1'b0;
      col_r            <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      col_r <= col_nxt;
    end
  end

  // Loads write at accept; every item reads the entry its step would need.
  lcdseq_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && (in_tuser == CMD_LOAD)),
    .wr_addr (in_tdata[5:1]),
    .wr_data (in_tdata[13:6]),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (store_data)
  );

  lcdseq_step #(
    .LINE_LENGTH (LINE_LENGTH),
    .COL_W       (COL_W)
  ) u_step (
    .cmd        (s1_cmd_r),
    .ms_passed  (s1_ms_r),
    .ctl        (ctl_r),
    .column     (col_r),
    .store_data (store_data),
    .ctl_nxt    (step_ctl),
    .column_nxt (step_col),
    .res        (step_res)
  );

  lcdseq_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .res_in     (step_res),
    .dev_addr   (dev_addr_r),
    .free       (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A committed step always shows up at the output.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("committed item produced no result");

  // A stalled work stage blocks new items, which would otherwise read stale state.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !emit_free |-> !in_tready)
    else $error("item accepted while the work stage is stalled");

endmodule

// File: src/lcdseq_store.sv
// Line store: 32 x 8 synchronous memory with one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses lcdseq_pkg.
module lcdseq_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lcdseq_pkg::STORE_AW-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           rd_en,
  input  logic [lcdseq_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                     rd_data
);
  import lcdseq_pkg::*;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [7:0]             rd_q_r;
  logic                   rd_vld_r;

  // Storage array, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 8'h00;

endmodule

// File: src/lcdseq_step.sv
// One sequencer step: next control state, next column and the result
// description of the item in the work stage. Uses lcdseq_pkg.
module lcdseq_step #(
  parameter int unsigned LINE_LENGTH = lcdseq_pkg::LINE_LEN_DEF,
  parameter int unsigned COL_W       = $clog2(LINE_LENGTH + 1)
) (
  input  logic [2:0]       cmd,
  input  logic             ms_passed,
  input  lcdseq_pkg::ctl_t ctl,
  input  logic [COL_W-1:0] column,
  input  logic [7:0]       store_data,
  output lcdseq_pkg::ctl_t ctl_nxt,
  output logic [COL_W-1:0] column_nxt,
  output lcdseq_pkg::res_t res
);
  import lcdseq_pkg::*;

  always_comb begin
    logic [5:0]      el;
    logic            bl;
    logic [7:0]      col8;
    logic [7:0]      ch;
    logic            ended;
    logic [7:0]      txt;
    logic [PH_W-1:0] after_text;

    el         = ctl.elapsed_ms + {5'd0, (ms_passed && (ctl.elapsed_ms != MS_MAX))};
    bl         = phase_lit(ctl.phase);
    col8       = 8'(column);
    ch         = (col8 < 8'(ROW_STRIDE)) ? store_data : 8'h00;
    ended      = ctl.line_ended || (ch == 8'h00);
    txt        = ended ? BYTE_SPACE : ch;
    after_text = (ctl.phase == PH_TEXT0) ? PH_CURSOR1 : PH_IDLE_ON;

    ctl_nxt            = ctl;
    ctl_nxt.elapsed_ms = el;
    column_nxt         = column;
    res                = '0;
    res.bl             = bl;

    // Command decode; only a poll whose wait has run out takes a step; send, on and off set the phase.
    unique case (cmd)
      CMD_POLL: begin
        if (el >= ctl.wait_ms) begin
          ctl_nxt.wait_ms    = '0;
          ctl_nxt.elapsed_ms = '0;
          unique case (ctl.phase)
            PH_INIT_START: begin
              ctl_nxt.phase   = PH_FS0;
              ctl_nxt.wait_ms = WAIT_STEP;
            end
            PH_FS0, PH_FS1, PH_FS2: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_NIBBLE;
              res.nib_hi      = NIB_FS8;
              ctl_nxt.phase   = ctl.phase + 4'd1;
              ctl_nxt.wait_ms = (ctl.phase == PH_FS0) ? WAIT_POWER : WAIT_STEP;
            end
            PH_FS3: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_NIBBLE;
              res.nib_hi      = NIB_FS4;
              ctl_nxt.phase   = PH_FUNC;
              ctl_nxt.wait_ms = WAIT_SHORT;
            end
            PH_FUNC: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_BYTE;
              {res.nib_hi, res.nib_lo} = BYTE_FUNC;
              ctl_nxt.phase   = PH_CTRL;
              ctl_nxt.wait_ms = WAIT_SHORT;
            end
            PH_CTRL: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_BYTE;
              {res.nib_hi, res.nib_lo} = BYTE_CTRL;
              ctl_nxt.phase   = PH_CLEAR;
              ctl_nxt.wait_ms = WAIT_SHORT;
            end
            PH_CLEAR: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_BYTE;
              {res.nib_hi, res.nib_lo} = BYTE_CLEAR;
              ctl_nxt.phase   = PH_IDLE_ON;
              ctl_nxt.wait_ms = WAIT_CLEAR;
            end
            PH_SEND_START: begin
              ctl_nxt.phase = PH_CURSOR0;
            end
            PH_CURSOR0, PH_CURSOR1: begin
              res.byte_valid     = 1'b1;
              res.last_idx       = LAST_BYTE;
              {res.nib_hi, res.nib_lo} =
                (ctl.phase == PH_CURSOR0) ? BYTE_LINE0 : BYTE_LINE1;
              ctl_nxt.phase      = ctl.phase + 4'd1;
              ctl_nxt.line_ended = 1'b0;
              ctl_nxt.wait_ms    = WAIT_LINE;
              column_nxt         = '0;
            end
            PH_TEXT0, PH_TEXT1: begin
              // One character per step; past the first zero the line is padded.
              if (col8 < 8'(LINE_LENGTH)) begin
                res.byte_valid     = 1'b1;
                res.last_idx       = LAST_BYTE;
                res.rs             = 1'b1;
                {res.nib_hi, res.nib_lo} = txt;
                ctl_nxt.line_ended = ended;
                column_nxt         = column + COL_W'(1);
              end else begin
                ctl_nxt.phase = after_text;
              end
              ctl_nxt.wait_ms = WAIT_STEP;
            end
            PH_TURN_OFF: begin
              res.byte_valid  = 1'b1;
              res.last_idx    = LAST_BYTE;
              {res.nib_hi, res.nib_lo} = BYTE_CLEAR;
              ctl_nxt.phase   = PH_IDLE_OFF;
            end
            default: begin
            end
          endcase
        end
      end
      CMD_SEND: ctl_nxt.phase = PH_SEND_START;
      CMD_ON:   ctl_nxt.phase = PH_IDLE_ON;
      CMD_OFF:  ctl_nxt.phase = PH_TURN_OFF;
      default: begin
      end
    endcase

    res.ready = (ctl_nxt.phase == PH_IDLE_ON);
    res.lit   = phase_lit(ctl_nxt.phase);
  end

endmodule

// File: src/lcdseq_emit.sv
// Output stage: holds one item's result description and sends its bus bytes one per
// cycle, while out_tready is high, on the result channel. Uses lcdseq_pkg.
module lcdseq_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  lcdseq_pkg::res_t res_in,
  input  logic [6:0]       dev_addr,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,   // bus_byte[7:0], ready_res[8], lit[9], target_address[16:10]
  output logic             out_tuser,   // byte_valid
  output logic             out_tlast
);
  import lcdseq_pkg::*;

  res_t       buf_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic [3:0] nib;
  logic [7:0] bus_byte;
  logic       take;

  assign take       = valid_r && out_tready;
  assign out_tlast  = (idx_r == buf_r.last_idx);
  assign free       = !valid_r || (take && out_tlast);
  assign out_tvalid = valid_r;

  // Even results carry enable high, odd ones low; the upper pair holds the low nibble.
  always_comb begin
    nib      = idx_r[1] ? buf_r.nib_lo : buf_r.nib_hi;
    bus_byte = buf_r.byte_valid ? {nib, buf_r.bl, ~idx_r[0], 1'b0, buf_r.rs} : 8'h00;
  end

  assign out_tdata = {7'd0, dev_addr, buf_r.lit, buf_r.ready, bus_byte};
  assign out_tuser = buf_r.byte_valid;

  // Result description, payload only.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res_in;
    end
  end

  // Occupancy and result index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (out_tlast) begin
        valid_r <= 1'b0;
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // An item without bytes yields a single result.
  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !buf_r.byte_valid |-> out_tlast)
    else $error("status-only item does not end on its first result");

  // A multi-byte item keeps its results coming.
  a_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result run broken before its last result");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for char_lcd_nibble_sequencer: a directed table, then random segments
// of loads, sends, power and reserved commands and poll runs, all checked against a predictor.
// Depends on lcdseq_pkg and the char_lcd_nibble_sequencer RTL.
module tb_top;
  import lcdseq_pkg::*;

  localparam int unsigned LINE_LEN = LINE_LEN_DEF;
  // Command codes that the block must ignore.
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  // Expander bits beside the nibble.
  localparam logic [7:0] XB_BACKLIGHT = 8'h08;
  localparam logic [7:0] XB_ENABLE    = 8'h04;
  // A repeat count of zero means: poll until the sequencer is idle.
  localparam int RUN_TO_IDLE   = 0;
  localparam int RUN_CAP       = 300;
  localparam int RAND_ITEMS    = 70;
  localparam int CFG_SPACING   = 25;
  localparam int SETTLE_CYCLES = 12;
  localparam int DIR_ROWS      = 19;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       byte_valid;
    logic       last;
    logic       ready_res;
    logic       lit;
    logic [6:0] addr;
  } lcd_res_t;

  typedef struct {
    logic [2:0] cmd;
    logic       ms;
    logic [4:0] idx;
    logic [7:0] code;
    int         reps;
    bit         typed;
    logic       rdy;
    logic       lit;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // ms_passed[0], char_index[5:1], char_code[13:6]
  logic [2:0]  in_tuser;    // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // bus_byte[7:0], ready_res[8], lit[9], target_address[16:10]
  logic        out_tuser;   // byte_valid
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  // Predicted sequencer state.
  logic [PH_W-1:0] seq_phase;
  logic [5:0]      wait_ms;
  logic [5:0]      elapsed_ms;
  logic [4:0]      column;
  logic            line_ended;
  logic [7:0]      line_store [STORE_DEPTH];
  logic [6:0]      dev_addr;

  logic [7:0] step_bytes [$];
  lcd_res_t   expected_q [$];
  dir_row_t   dir_table [DIR_ROWS];

  int errors = 0;
  int items_sent;
  bit tx_calm;
  int rx_stall_left = 0;
  int rx_calm_left = 0;

  char_lcd_nibble_sequencer #(.LINE_LENGTH(LINE_LEN)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The backlight stays on except while turning off or idle off.
  function automatic logic shows_backlight(input logic [PH_W-1:0] ph);
    return !(ph == PH_TURN_OFF || ph == PH_IDLE_OFF);
  endfunction

  // One nibble leaves as two expander bytes, enable high then low.
  task automatic emit_nibble(input logic [3:0] nib, input logic rs, input logic bl);
    logic [7:0] b;
    b = {nib, 4'b0000} | (bl ? XB_BACKLIGHT : 8'h00) | {7'b0, rs};
    step_bytes.push_back(b | XB_ENABLE);
    step_bytes.push_back(b);
  endtask

  task automatic emit_byte(input logic [7:0] v, input logic rs, input logic bl);
    emit_nibble(v[7:4], rs, bl);
    emit_nibble(v[3:0], rs, bl);
  endtask

  // One character of a line; after the first zero byte the line is padded with spaces.
  task automatic text_step(input logic row, input logic [PH_W-1:0] nxt, input logic bl);
    logic [7:0] ch;
    if (column < LINE_LEN) begin
      ch = 8'h00;
      if (column < ROW_STRIDE) ch = line_store[{row, column[ROW_AW-1:0]}];
      if (ch == 8'h00) line_ended = 1'b1;
      emit_byte(line_ended ? BYTE_SPACE : ch, 1'b1, bl);
      column = column + 5'd1;
    end else begin
      seq_phase = nxt;
    end
    wait_ms = WAIT_STEP;
  endtask

  // One sequencer step; the backlight bit comes from the phase before the step.
  task automatic sequencer_step;
    logic bl;
    bl = shows_backlight(seq_phase);
    wait_ms = 6'd0;
    elapsed_ms = 6'd0;
    case (seq_phase)
      PH_INIT_START: begin
        seq_phase = PH_FS0;
        wait_ms = WAIT_STEP;
      end
      PH_FS0: begin
        emit_nibble(NIB_FS8, 1'b0, bl);
        seq_phase = PH_FS1;
        wait_ms = WAIT_POWER;
      end
      PH_FS1: begin
        emit_nibble(NIB_FS8, 1'b0, bl);
        seq_phase = PH_FS2;
        wait_ms = WAIT_STEP;
      end
      PH_FS2: begin
        emit_nibble(NIB_FS8, 1'b0, bl);
        seq_phase = PH_FS3;
        wait_ms = WAIT_STEP;
      end
      PH_FS3: begin
        emit_nibble(NIB_FS4, 1'b0, bl);
        seq_phase = PH_FUNC;
        wait_ms = WAIT_SHORT;
      end
      PH_FUNC: begin
        emit_byte(BYTE_FUNC, 1'b0, bl);
        seq_phase = PH_CTRL;
        wait_ms = WAIT_SHORT;
      end
      PH_CTRL: begin
        emit_byte(BYTE_CTRL, 1'b0, bl);
        seq_phase = PH_CLEAR;
        wait_ms = WAIT_SHORT;
      end
      PH_CLEAR: begin
        emit_byte(BYTE_CLEAR, 1'b0, bl);
        seq_phase = PH_IDLE_ON;
        wait_ms = WAIT_CLEAR;
      end
      PH_SEND_START: seq_phase = PH_CURSOR0;
      PH_CURSOR0: begin
        emit_byte(BYTE_LINE0, 1'b0, bl);
        seq_phase = PH_TEXT0;
        column = 5'd0;
        line_ended = 1'b0;
        wait_ms = WAIT_LINE;
      end
      PH_TEXT0: text_step(1'b0, PH_CURSOR1, bl);
      PH_CURSOR1: begin
        emit_byte(BYTE_LINE1, 1'b0, bl);
        seq_phase = PH_TEXT1;
        column = 5'd0;
        line_ended = 1'b0;
        wait_ms = WAIT_LINE;
      end
      PH_TEXT1: text_step(1'b1, PH_IDLE_ON, bl);
      PH_TURN_OFF: begin
        emit_byte(BYTE_CLEAR, 1'b0, bl);
        seq_phase = PH_IDLE_OFF;
      end
      default: ;
    endcase
  endtask

  // Advance the predicted state by one item and queue its results. A typed row
  // supplies its own single no-bytes result instead of the predicted ones.
  task automatic predict_results(input logic [2:0] cmd, input logic ms, input logic [4:0] idx,
                                 input logic [7:0] code, input bit typed, input logic rdy,
                                 input logic lit_e);
    lcd_res_t r;
    step_bytes.delete();
    if (ms && elapsed_ms < MS_MAX) elapsed_ms = elapsed_ms + 6'd1;
    case (cmd)
      CMD_POLL: if (elapsed_ms >= wait_ms) sequencer_step();
      CMD_LOAD: line_store[idx] = code;
      CMD_SEND: seq_phase = PH_SEND_START;
      CMD_ON:   seq_phase = PH_IDLE_ON;
      CMD_OFF:  seq_phase = PH_TURN_OFF;
      default: ;
    endcase
    r.ready_res = (seq_phase == PH_IDLE_ON);
    r.lit = shows_backlight(seq_phase);
    r.addr = dev_addr;
    if (typed) begin
      r.ready_res = rdy;
      r.lit = lit_e;
      r.bus_byte = 8'h00;
      r.byte_valid = 1'b0;
      r.last = 1'b1;
      expected_q.push_back(r);
    end else if (step_bytes.size() == 0) begin
      r.bus_byte = 8'h00;
      r.byte_valid = 1'b0;
      r.last = 1'b1;
      expected_q.push_back(r);
    end else begin
      foreach (step_bytes[k]) begin
        r.bus_byte = step_bytes[k];
        r.byte_valid = 1'b1;
        r.last = (k == step_bytes.size() - 1);
        expected_q.push_back(r);
      end
    end
  endtask

  // Present one item, after a random gap unless tx_calm is set, and hold it until it is taken.
  task automatic send_item(input logic [2:0] cmd, input logic ms, input logic [4:0] idx,
                           input logic [7:0] code, input bit typed, input logic rdy,
                           input logic lit_e);
    int gap;
    int roll;
    gap = 0;
    if (!tx_calm) begin
      roll = $urandom_range(99);
      if (roll >= 92) gap = $urandom_range(30, 6);
      else if (roll >= 55) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, code, idx, ms};
    predict_results(cmd, ms, idx, code, typed, rdy, lit_e);
    if (cmd <= CMD_OFF) items_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // A stretch of polls with random side fields; optionally stops once idle.
  task automatic run_polls(input int count, input bit to_idle, input int ms_pct);
    for (int i = 0; i < count; i++) begin
      if (to_idle && (seq_phase == PH_IDLE_ON || seq_phase == PH_IDLE_OFF)) break;
      send_item(CMD_POLL, $urandom_range(99) < ms_pct, 5'($urandom_range(31)),
                8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
    end
  endtask

  // Stop sending, wait for every expected result, then let the pipeline settle.
  task automatic drain_and_settle;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [6:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    dev_addr = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result receiver: random stalls, mostly short, with occasional long ones and calm stretches.
  always @(posedge clk) begin : rx_pacing
    int roll;
    if (rx_calm_left > 0) begin
      rx_calm_left--;
      out_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        rx_calm_left = $urandom_range(200, 50);
        out_tready <= 1'b1;
      end else if (roll < 25) begin
        rx_stall_left = (roll < 22) ? $urandom_range(2) : $urandom_range(20, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    lcd_res_t got;
    lcd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.bus_byte = out_tdata[7:0];
      got.ready_res = out_tdata[8];
      got.lit = out_tdata[9];
      got.addr = out_tdata[16:10];
      got.byte_valid = out_tuser;
      got.last = out_tlast;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("bus_byte", int'(want.bus_byte), int'(got.bus_byte));
        check_field("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
        check_field("last", int'(want.last), int'(got.last));
        check_field("ready_res", int'(want.ready_res), int'(got.ready_res));
        check_field("lit", int'(want.lit), int'(got.lit));
        check_field("target_address", int'(want.addr), int'(got.addr));
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int roll;
    int rand_base;
    int next_cfg;
    int cfg_no;
    logic [6:0] cfg_plan [3];
    logic [2:0] noise_cmd;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= CMD_POLL;
    in_tdata <= 16'h0000;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 7'h00;
    items_sent = 0;
    tx_calm = 1'b0;

    seq_phase = PH_INIT_START;
    wait_ms = 6'd0;
    elapsed_ms = 6'd0;
    column = 5'd0;
    line_ended = 1'b0;
    dev_addr = 7'h00;
    foreach (line_store[i]) line_store[i] = 8'h00;

    // Directed rows: reset state, store extremes, ignored commands, the full power-up,
    // millisecond saturation, a full send with early line ends, turn-off and turn-on.
    dir_table = '{
      '{CMD_POLL,    1'b0, 5'd0,  8'h00, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_POLL,    1'b1, 5'd31, 8'hFF, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_LOAD,    1'b1, 5'd0,  8'hFF, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_LOAD,    1'b0, 5'd31, 8'h01, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_LOAD,    1'b1, 5'd16, 8'h80, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_LOAD,    1'b1, 5'd1,  8'h00, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_RSVD_LO, 1'b1, 5'd31, 8'hFF, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_RSVD_HI, 1'b0, 5'd0,  8'h00, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_POLL,    1'b0, 5'd10, 8'h55, 1,           1'b0, 1'b0, 1'b0},
      '{CMD_LOAD,    1'b1, 5'd20, 8'hAA, 66,          1'b1, 1'b0, 1'b1},
      '{CMD_POLL,    1'b0, 5'd0,  8'h00, 1,           1'b0, 1'b0, 1'b0},
      '{CMD_POLL,    1'b1, 5'd0,  8'h00, RUN_TO_IDLE, 1'b0, 1'b0, 1'b0},
      '{CMD_POLL,    1'b0, 5'd0,  8'h00, 1,           1'b1, 1'b1, 1'b1},
      '{CMD_SEND,    1'b1, 5'd0,  8'h00, 1,           1'b1, 1'b0, 1'b1},
      '{CMD_POLL,    1'b1, 5'd0,  8'h00, RUN_TO_IDLE, 1'b0, 1'b0, 1'b0},
      '{CMD_OFF,     1'b1, 5'd0,  8'h00, 1,           1'b1, 1'b0, 1'b0},
      '{CMD_POLL,    1'b1, 5'd0,  8'h00, RUN_TO_IDLE, 1'b0, 1'b0, 1'b0},
      '{CMD_POLL,    1'b0, 5'd0,  8'h00, 1,           1'b1, 1'b0, 1'b0},
      '{CMD_ON,      1'b0, 5'd0,  8'h00, 1,           1'b1, 1'b1, 1'b1}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_address(7'h7F);

    foreach (dir_table[r]) begin
      if (dir_table[r].reps == RUN_TO_IDLE) begin
        run_polls(RUN_CAP, 1'b1, 100);
      end else begin
        repeat (dir_table[r].reps)
          send_item(dir_table[r].cmd, dir_table[r].ms, dir_table[r].idx, dir_table[r].code,
                    dir_table[r].typed, dir_table[r].rdy, dir_table[r].lit);
      end
    end

    // Random segments, with an address change at idle points along the way.
    cfg_plan[0] = 7'h00;
    cfg_plan[1] = 7'($urandom_range(126, 1));
    cfg_plan[2] = 7'($urandom_range(127));
    cfg_no = 0;
    next_cfg = 0;
    rand_base = items_sent;
    while (items_sent - rand_base < RAND_ITEMS) begin
      if (cfg_no < 3 && items_sent - rand_base >= next_cfg) begin
        drain_and_settle();
        write_address(cfg_plan[cfg_no]);
        cfg_no++;
        next_cfg += CFG_SPACING;
      end
      tx_calm = ($urandom_range(99) < 20);
      roll = $urandom_range(99);
      if (roll < 28) begin
        // Burst of character loads, a quarter of them line ends.
        repeat ($urandom_range(6, 1))
          send_item(CMD_LOAD, 1'($urandom_range(1)), 5'($urandom_range(31)),
                    ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1)),
                    1'b0, 1'b0, 1'b0);
      end else if (roll < 55) begin
        run_polls($urandom_range(40, 5), 1'b0, 85);
      end else if (roll < 70) begin
        // A send, either carried to the end or broken off.
        send_item(CMD_SEND, 1'($urandom_range(1)), 5'($urandom_range(31)),
                  8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        if ($urandom_range(1)) run_polls(RUN_CAP, 1'b1, 85);
        else run_polls($urandom_range(80, 10), 1'b0, 85);
      end else if (roll < 90) begin
        send_item((roll < 80) ? CMD_ON : CMD_OFF, 1'($urandom_range(1)),
                  5'($urandom_range(31)), 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        run_polls($urandom_range(12), 1'b0, 85);
      end else if (roll < 95) begin
        repeat ($urandom_range(3, 1)) begin
          noise_cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
          send_item(noise_cmd, 1'($urandom_range(1)), 5'($urandom_range(31)),
                    8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        end
      end else begin
        run_polls(RUN_CAP, 1'b1, 85);
      end
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
